// ----- hdl/fixed_point_radix_formatter_unit_macros.svh -----
// assertion macros for the fixed-point radix formatter
`ifndef FIXED_POINT_RADIX_FORMATTER_UNIT_MACROS_SVH
`define FIXED_POINT_RADIX_FORMATTER_UNIT_MACROS_SVH
`ifndef SYNTH
// antecedent and consequent in the same cycle
`define FRFMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frfmt assertion failed");
// consequent in the cycle after the antecedent
`define FRFMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frfmt assertion failed");
`else
`define FRFMT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FRFMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/frfmt_pkg.sv -----
// shared constants, types and helpers for the radix formatter
package frfmt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRACTION_DIGITS = 2;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;
    // digit counter only needs to tell below, at and above the point position
    localparam int NDIG_W          = $clog2(FRACTION_DIGITS + 2);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_POINT  = CHAR_W'(8'h2e);
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = CHAR_W'(8'h2d);
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(8'h61);

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < RADIX_W'(10))
        begin
            res = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            res = CHAR_LOWER_A + CHAR_W'(d - RADIX_W'(10));
        end
        return res;
    endfunction

endpackage

// ----- hdl/frfmt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module frfmt_ram #(
    parameter int WIDTH  = 7,
    parameter int DEPTH  = 36,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/frfmt_div.sv -----
// bit-serial restoring divider: magnitude by radix, one quotient bit per cycle
module frfmt_div #(
    parameter int MAG_W = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  frfmt_pkg::div_ctrl_t            ctrl,
    input  logic [MAG_W-1:0]                dividend,
    input  logic [frfmt_pkg::RADIX_W-1:0]   divisor,
    output frfmt_pkg::div_stat_t            stat,
    output logic [MAG_W-1:0]                quotient,
    output logic [frfmt_pkg::RADIX_W-1:0]   remainder
);

    localparam int RW    = frfmt_pkg::RADIX_W;
    localparam int BIT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] quo_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    dvs_reg;
    logic [BIT_W-1:0] bit_cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RW:0]      shifted;
    logic [RW:0]      diff;
    logic             fits;
    logic [RW-1:0]    rem_next;
    logic [MAG_W-1:0] quo_next;

    // dividend bits leave the top of the quotient register as quotient bits enter below
    assign shifted  = {rem_reg, quo_reg[MAG_W-1]};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = fits ? diff[RW-1:0] : shifted[RW-1:0];
    assign quo_next = {quo_reg[MAG_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (ctrl.start)
        begin
            bit_cnt_reg <= BIT_W'(MAG_W);
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
            if (bit_cnt_reg == BIT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/fixed_point_radix_formatter_unit.sv -----
// top level of the fixed-point radix formatter: sequencer, character buffer, output register
//
// Usage: a signed value (real value times radix squared) is taken on the value channel
// (value_valid / value_ready). The text comes out one ASCII character per transfer on the
// character channel (character_valid / character_ready), most significant first: an
// optional '-', the digits, and '.' before the two lowest digits; last marks the end.
// radix is written through radix_write_enable; the user must write it only while the block
// is idle, the block does not enforce it. Codes below 2 act as 2 and above 36 act as 36.
// Sequence: one item at a time. Each digit is one run of the bit-serial divider (start,
// VALUE_WIDTH-1 quotient bits, done) and a digit write; the point and sign take a state
// each, and a short value adds states for padding, '.' and '0'; each character then passes
// buffer read, load and offer, plus any receiver stall.
// value_ready is high only while idle, so a new item waits until the last character of
// the previous one has been transferred.
// A stalled receiver simply holds the current character and last stable.
// Reset: rst_n clears the sequencer and sets radix to 10; character_valid is low and
// value_ready is high from reset on.
`include "fixed_point_radix_formatter_unit_macros.svh"

module fixed_point_radix_formatter_unit #(
    parameter int VALUE_WIDTH = frfmt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             radix_write_enable,
    input  logic [frfmt_pkg::RADIX_W-1:0]    radix,
    input  logic                             value_valid,
    output logic                             value_ready,
    input  logic signed [VALUE_WIDTH-1:0]    value,
    output logic                             character_valid,
    input  logic                             character_ready,
    output logic [frfmt_pkg::CHAR_W-1:0]     character,
    output logic                             last
);

    localparam int RW        = frfmt_pkg::RADIX_W;
    localparam int CW        = frfmt_pkg::CHAR_W;
    localparam int NW        = frfmt_pkg::NDIG_W;
    localparam int MAG_W     = VALUE_WIDTH - 1;
    localparam int BUF_DEPTH = VALUE_WIDTH + frfmt_pkg::FRACTION_DIGITS + 2;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam logic [NW-1:0] NDIG_POINT = NW'(frfmt_pkg::FRACTION_DIGITS);
    localparam logic [NW-1:0] NDIG_SAT   = {NW{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT,
        ST_DIGIT,
        ST_POINT,
        ST_PAD,
        ST_PT2,
        ST_ZERO,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [RW-1:0]     radix_reg;
    logic [RW-1:0]     base_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [NW-1:0]     ndig_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CW-1:0]     char_reg;
    logic              last_reg;

    logic [VALUE_WIDTH-1:0] abs_val;
    logic [MAG_W-1:0]       mag_sat;
    logic [NW-1:0]          ndig_inc;

    frfmt_pkg::div_ctrl_t div_ctrl;
    frfmt_pkg::div_stat_t div_stat;
    logic [MAG_W-1:0]     quotient;
    logic [RW-1:0]        remainder;

    logic              buf_we;
    logic [CW-1:0]     buf_wdata;
    logic [CNT_W-1:0]  rd_idx;
    logic [CW-1:0]     buf_rdata;

    // only the most negative input reaches the top bit; it saturates
    assign abs_val  = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
    assign mag_sat  = abs_val[VALUE_WIDTH-1] ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
    assign ndig_inc = (ndig_reg == NDIG_SAT) ? NDIG_SAT : ndig_reg + NW'(1);

    assign div_ctrl.start = (state_reg == ST_DIV);

    frfmt_div #(
        .MAG_W(MAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (mag_reg),
        .divisor  (base_reg),
        .stat     (div_stat),
        .quotient (quotient),
        .remainder(remainder)
    );

    always_comb
    begin
        buf_we    = 1'b0;
        buf_wdata = frfmt_pkg::CHAR_ZERO;
        case (state_reg)
            ST_DIGIT:
            begin
                buf_we    = 1'b1;
                buf_wdata = frfmt_pkg::digit_char(remainder);
            end
            ST_POINT, ST_PT2:
            begin
                buf_we    = 1'b1;
                buf_wdata = frfmt_pkg::CHAR_POINT;
            end
            ST_PAD:
            begin
                buf_we    = (ndig_reg < NDIG_POINT);
                buf_wdata = frfmt_pkg::CHAR_ZERO;
            end
            ST_ZERO:
            begin
                buf_we    = 1'b1;
                buf_wdata = frfmt_pkg::CHAR_ZERO;
            end
            ST_SIGN:
            begin
                buf_we    = neg_reg;
                buf_wdata = frfmt_pkg::CHAR_MINUS;
            end
            default:
            begin
                buf_we    = 1'b0;
                buf_wdata = frfmt_pkg::CHAR_ZERO;
            end
        endcase
    end

    // characters are stored least significant first and read back from the top
    assign rd_idx = count_reg - CNT_W'(1);

    frfmt_ram #(
        .WIDTH (CW),
        .DEPTH (BUF_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_buf (
        .clk  (clk),
        .we   (buf_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(buf_wdata),
        .raddr(rd_idx[ADDR_W-1:0]),
        .rdata(buf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= frfmt_pkg::RADIX_RESET;
            base_reg  <= frfmt_pkg::RADIX_RESET;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ndig_reg  <= '0;
            count_reg <= '0;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (radix_write_enable)
            begin
                radix_reg <= radix;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (value_valid)
                    begin
                        neg_reg   <= value[VALUE_WIDTH-1];
                        mag_reg   <= mag_sat;
                        base_reg  <= frfmt_pkg::clamp_radix(radix_reg);
                        ndig_reg  <= '0;
                        count_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_DIGIT;
                    end
                end
                ST_DIGIT:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    mag_reg   <= quotient;
                    ndig_reg  <= ndig_inc;
                    if (quotient != '0)
                    begin
                        state_reg <= (ndig_inc == NDIG_POINT) ? ST_POINT : ST_DIV;
                    end
                    else
                    begin
                        state_reg <= (ndig_inc <= NDIG_POINT) ? ST_PAD : ST_SIGN;
                    end
                end
                ST_POINT:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_DIV;
                end
                ST_PAD:
                begin
                    if (ndig_reg < NDIG_POINT)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        ndig_reg  <= ndig_inc;
                    end
                    else
                    begin
                        state_reg <= ST_PT2;
                    end
                end
                ST_PT2:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_ZERO;
                end
                ST_ZERO:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_SIGN;
                end
                ST_SIGN:
                begin
                    if (neg_reg)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    count_reg <= rd_idx;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    char_reg  <= buf_rdata;
                    last_reg  <= (count_reg == '0);
                    state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (character_ready)
                    begin
                        state_reg <= last_reg ? ST_IDLE : ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign value_ready     = (state_reg == ST_IDLE);
    assign character_valid = (state_reg == ST_HOLD);
    assign character       = char_reg;
    assign last            = last_reg;

    `FRFMT_ASSERT_SAME(a_no_overlap, clk, rst_n, value_ready, !character_valid)
    `FRFMT_ASSERT_SAME(a_done_in_wait, clk, rst_n, div_stat.done, state_reg == ST_WAIT)
    `FRFMT_ASSERT_NEXT(a_last_frees_input, clk, rst_n,
        character_valid && character_ready && last, value_ready)
    `FRFMT_ASSERT_NEXT(a_stall_holds, clk, rst_n, character_valid && !character_ready,
        character_valid && $stable(character) && $stable(last))

endmodule

// ----- tb/sv/fixed_point_radix_formatter_checker.sv -----
// character stream predictor and comparator for the fixed-point radix formatter
`timescale 1ns / 100ps

module fixed_point_radix_formatter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          radix_write_enable,
    input  logic [frfmt_pkg::RADIX_W-1:0] radix,
    input  logic                          value_valid,
    input  logic                          value_ready,
    input  logic signed [31:0]            value,
    input  logic                          character_valid,
    input  logic                          character_ready,
    input  logic [frfmt_pkg::CHAR_W-1:0]  character,
    input  logic                          last,
    output int                            fail_count,
    output int                            chars_outstanding
);

    localparam int POINT_POS = 2;
    localparam logic [6:0] ASCII_POINT   = 7'h2e;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_MINUS   = 7'h2d;
    localparam logic [6:0] ASCII_LETTERS = 7'h61;
    localparam logic [5:0] BASE_RESET    = 6'd10;
    localparam logic [31:0] MAG_CEILING  = 32'h7fff_ffff;

    typedef struct packed {
        logic [6:0] code;
        logic       tail;
    } text_char_t;

    logic [5:0] radix_now;
    text_char_t expected_text[$];

    // builds the text least significant first, then queues it in transfer order
    function automatic void predict_text(input logic signed [31:0] v, input logic [5:0] r);
        logic [6:0]  rev [0:35];
        logic [31:0] base;
        logic [31:0] mag;
        logic [31:0] digit;
        logic        neg;
        int          n;
        int          nd;
        text_char_t  item;
        base = (r < 6'd2) ? 32'd2 : ((r > 6'd36) ? 32'd36 : 32'(r));
        neg = v[31];
        mag = neg ? (~v + 32'd1) : v;
        if (mag > MAG_CEILING)
        begin
            mag = MAG_CEILING;
        end
        n = 0;
        nd = 0;
        do
        begin
            if (nd == POINT_POS)
            begin
                rev[n] = ASCII_POINT;
                n++;
            end
            digit = mag % base;
            rev[n] = (digit < 32'd10) ? ASCII_ZERO + 7'(digit) : ASCII_LETTERS + 7'(digit - 32'd10);
            n++;
            nd++;
            mag = mag / base;
        end
        while (mag > 0);
        // short magnitudes read 0.0d or 0.dd
        if (nd <= POINT_POS)
        begin
            while (nd < POINT_POS)
            begin
                rev[n] = ASCII_ZERO;
                n++;
                nd++;
            end
            rev[n] = ASCII_POINT;
            n++;
            rev[n] = ASCII_ZERO;
            n++;
        end
        if (neg)
        begin
            rev[n] = ASCII_MINUS;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            item.code = rev[k];
            item.tail = (k == 0);
            expected_text.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            radix_now = BASE_RESET;
            expected_text.delete();
            fail_count = 0;
            chars_outstanding <= 0;
        end
        else
        begin
            if (radix_write_enable)
            begin
                radix_now = radix;
            end
            if (value_valid && value_ready)
            begin
                predict_text(value, radix_now);
            end
            if (character_valid && character_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected character transfer: expected none, actual %h last %b",
                             $time, character, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.code)
                    begin
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.code, character);
                        fail_count++;
                    end
                    if (last !== want.tail)
                    begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.tail, last);
                        fail_count++;
                    end
                end
            end
            // registered with a nonblocking assignment, so the stimulus sees no race on the count
            chars_outstanding <= expected_text.size();
        end
    end

endmodule

// ----- tb/sv/tb_fixed_point_radix_formatter_unit.sv -----
// stimulus and verdict for the fixed-point radix formatter
`timescale 1ns / 100ps

module tb_fixed_point_radix_formatter_unit;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 50;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 800;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 16;
    localparam int DIRECTED     = 20;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          radix_write_enable = 1'b0;
    logic [frfmt_pkg::RADIX_W-1:0] radix = '0;
    logic                          value_valid = 1'b0;
    logic                          value_ready;
    logic signed [31:0]            value = '0;
    logic                          character_valid;
    logic                          character_ready = 1'b0;
    logic [frfmt_pkg::CHAR_W-1:0]  character;
    logic                          last;
    logic                          quiet_phase = 1'b0;
    int                            fail_count;
    int                            chars_outstanding;
    int                            cycle_count = 0;
    int                            char_transfers = 0;

    logic signed [31:0]            directed_values [0:DIRECTED-1];
    logic [frfmt_pkg::RADIX_W-1:0] radix_plan [0:PHASES-1];

    fixed_point_radix_formatter_unit uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .radix_write_enable (radix_write_enable),
        .radix              (radix),
        .value_valid        (value_valid),
        .value_ready        (value_ready),
        .value              (value),
        .character_valid    (character_valid),
        .character_ready    (character_ready),
        .character          (character),
        .last               (last)
    );

    fixed_point_radix_formatter_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .radix_write_enable (radix_write_enable),
        .radix              (radix),
        .value_valid        (value_valid),
        .value_ready        (value_ready),
        .value              (value),
        .character_valid    (character_valid),
        .character_ready    (character_ready),
        .character          (character),
        .last               (last),
        .fail_count         (fail_count),
        .chars_outstanding  (chars_outstanding)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_fixed_point_radix_formatter_unit: FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return quiet_phase ? 0 : $urandom_range(0, 9);
    endfunction

    // mostly sized magnitudes so every digit count shows up, some raw words and extremes
    function automatic logic signed [31:0] random_value();
        logic signed [31:0] result;
        logic [31:0]        mag;
        int                 w;
        case ($urandom_range(0, 9))
            0: result = $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: result = 32'sd0;
                    1: result = 32'sh7fff_ffff;
                    2: result = 32'sh8000_0001;
                    3: result = 32'sh8000_0000;
                    default: result = 32'($urandom_range(0, 99));
                endcase
            end
            default:
            begin
                w = $urandom_range(1, 31);
                mag = $urandom & ((32'd1 << w) - 32'd1);
                result = $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
        return result;
    endfunction

    task automatic offer_value(input logic signed [31:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value <= v;
        value_valid <= 1'b1;
        do
            @(posedge clk);
        while (!value_ready);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (chars_outstanding != 0);
    endtask

    task automatic set_radix(input logic [frfmt_pkg::RADIX_W-1:0] r);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        radix <= r;
        radix_write_enable <= 1'b1;
        @(posedge clk);
        radix_write_enable <= 1'b0;
    endtask

    // character receiver, with one long hold-off so the block backs up
    initial
    begin
        int gap;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                character_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            character_ready <= 1'b1;
            do
                @(posedge clk);
            while (!character_valid);
            char_transfers++;
            if (char_transfers == HOLD_AT)
            begin
                character_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin
        directed_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd5, 32'sd9, 32'sd10, 32'sd42,
                            -32'sd99, 32'sd99, 32'sd100, -32'sd100, 32'sd101, 32'sd12345,
                            -32'sd987654321, 32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0000,
                            32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1000000000};
        radix_plan[0] = 6'd2;
        radix_plan[1] = 6'd36;
        radix_plan[2] = 6'd16;
        radix_plan[3] = 6'd0;
        radix_plan[4] = 6'd63;
        radix_plan[5] = 6'd10;
        radix_plan[6] = 6'd1;
        radix_plan[7] = 6'd37;
        radix_plan[8] = 6'($urandom_range(2, 36));
        radix_plan[9] = 6'($urandom_range(0, 63));
        radix_plan[10] = 6'd8;
        radix_plan[11] = 6'($urandom_range(0, 63));
        do
            @(posedge clk);
        while (!rst_n);

        // radix left at its reset value for the directed values
        for (int i = 0; i < DIRECTED; i++)
        begin
            offer_value(directed_values[i]);
        end
        value_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_radix(radix_plan[p]);
            quiet_phase <= (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                offer_value(random_value());
            end
            value_valid <= 1'b0;
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0 && chars_outstanding == 0)
        begin
            $display("tb_fixed_point_radix_formatter_unit: PASS");
        end
        else
        begin
            $display("tb_fixed_point_radix_formatter_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- fixed_point_radix_formatter_unit.f -----
+incdir+hdl
hdl/frfmt_pkg.sv
hdl/frfmt_ram.sv
hdl/frfmt_div.sv
hdl/fixed_point_radix_formatter_unit.sv
tb/sv/fixed_point_radix_formatter_checker.sv
tb/sv/tb_fixed_point_radix_formatter_unit.sv
